### hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// Config line tokenizer package
// Shared types, character codes and character class helpers.
// ----------------------------------------------------------------------------
package clt_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ROLE_DROP  = 2'd0,
    ROLE_FIRST = 2'd1,
    ROLE_CONT  = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_STRING  = 2'd1,
    KIND_PUNCT   = 2'd2,
    KIND_COMMENT = 2'd3
  } kind_t;

  typedef struct packed {
    mode_t mode;
    logic  esc;
  } scan_state_t;

  typedef struct packed {
    role_t role;
    kind_t kind;
  } label_t;

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_EQUAL     = 8'h3d;
  localparam logic [7:0] CHAR_COLON     = 8'h3a;
  localparam logic [7:0] CHAR_COMMA     = 8'h2c;
  localparam logic [7:0] CHAR_MINUS     = 8'h2d;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5b;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5d;
  localparam logic [7:0] CHAR_LBRACE    = 8'h7b;
  localparam logic [7:0] CHAR_RBRACE    = 8'h7d;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_IDLE, esc: 1'b0};

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CHAR_EQUAL) || (c == CHAR_COLON) || (c == CHAR_COMMA) ||
           (c == CHAR_MINUS) || (c == CHAR_LBRACKET) || (c == CHAR_RBRACKET) ||
           (c == CHAR_LBRACE) || (c == CHAR_RBRACE);
  endfunction

endpackage

### hw/rtl/clt_in_if.sv
// ----------------------------------------------------------------------------
// Config line tokenizer input channel
// Valid/ready channel that carries one character of a line per word.
// ----------------------------------------------------------------------------
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       line_end;

  modport source (output valid, output byte_in, output line_end, input ready);
  modport sink   (input valid, input byte_in, input line_end, output ready);
endinterface

### hw/rtl/clt_out_if.sv
// ----------------------------------------------------------------------------
// Config line tokenizer output channel
// Valid/ready channel that carries one labeled character per word.
// ----------------------------------------------------------------------------
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] role;
  logic [1:0] kind;
  logic       last_of_line;

  modport source (output valid, output byte_out, output role, output kind,
                  output last_of_line, input ready);
  modport sink   (input valid, input byte_out, input role, input kind,
                  input last_of_line, output ready);
endinterface

### hw/rtl/clt_classify.sv
// ----------------------------------------------------------------------------
// Config line tokenizer character classifier
// Labels one character from the scan state and computes the next state.
// ----------------------------------------------------------------------------
module clt_classify (
  input  logic                 [7:0] byte_in,
  input  logic                       line_end,
  input  clt_pkg::scan_state_t       state,
  output clt_pkg::label_t            label,
  output clt_pkg::scan_state_t       state_next
);

  logic             blank;
  logic             punct;
  clt_pkg::label_t  start_label;
  clt_pkg::mode_t   start_mode;

  assign blank = clt_pkg::is_blank(byte_in);
  assign punct = clt_pkg::is_punct(byte_in);

  always_comb begin
    start_label = '{role: clt_pkg::ROLE_FIRST, kind: clt_pkg::KIND_WORD};
    start_mode  = clt_pkg::MODE_WORD;
    if (blank) begin
      start_label = '{role: clt_pkg::ROLE_DROP, kind: clt_pkg::KIND_WORD};
      start_mode  = clt_pkg::MODE_IDLE;
    end else if (byte_in == clt_pkg::CHAR_QUOTE) begin
      start_label.kind = clt_pkg::KIND_STRING;
      start_mode       = clt_pkg::MODE_STRING;
    end else if (punct) begin
      start_label.kind = clt_pkg::KIND_PUNCT;
      start_mode       = clt_pkg::MODE_IDLE;
    end else if (byte_in == clt_pkg::CHAR_HASH) begin
      start_label.kind = clt_pkg::KIND_COMMENT;
      start_mode       = clt_pkg::MODE_COMMENT;
    end
  end

  always_comb begin
    label           = start_label;
    state_next.mode = state.mode;
    unique case (state.mode)
      clt_pkg::MODE_WORD: begin
        if (!state.esc && (blank || punct)) begin
          label           = start_label;
          state_next.mode = start_mode;
        end else begin
          label = '{role: clt_pkg::ROLE_CONT, kind: clt_pkg::KIND_WORD};
        end
      end
      clt_pkg::MODE_STRING: begin
        label = '{role: clt_pkg::ROLE_CONT, kind: clt_pkg::KIND_STRING};
        if (byte_in == clt_pkg::CHAR_QUOTE && !state.esc) begin
          state_next.mode = clt_pkg::MODE_IDLE;
        end
      end
      clt_pkg::MODE_COMMENT: begin
        label = '{role: clt_pkg::ROLE_CONT, kind: clt_pkg::KIND_COMMENT};
      end
      clt_pkg::MODE_IDLE: begin
        label           = start_label;
        state_next.mode = start_mode;
      end
      default: begin
        label           = start_label;
        state_next.mode = start_mode;
      end
    endcase
    state_next.esc = (byte_in == clt_pkg::CHAR_BACKSLASH);
    if (line_end) begin
      state_next = clt_pkg::SCAN_RESET;
    end
  end

endmodule

### hw/rtl/config_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Config line tokenizer
// Labels each character of a config line as blank, token start or token
// continuation, together with the kind of its token.
// ----------------------------------------------------------------------------
// A word accepted on the input is held in the input register, then moved to the result register that drives the output.
// Throughput: one word per cycle while the output is not stalled; the scan mode and
// escape flag register is updated once per word as it moves from the input to the result register.
// Reset: synchronous rst empties both registers and returns the scan state
// to idle with no pending escape.
module config_line_tokenizer (
  input  logic      clk,
  input  logic      rst,
  clt_in_if.sink    char_in,
  clt_out_if.source tok_out
);

  logic                 valid_q;
  logic           [7:0] byte_q;
  logic                 end_q;
  logic                 advance;
  clt_pkg::scan_state_t state;
  clt_pkg::scan_state_t state_next;
  clt_pkg::label_t      label;

  assign advance       = valid_q && (!tok_out.valid || tok_out.ready);
  assign char_in.ready = !valid_q || advance;

  clt_classify u_classify (
    .byte_in    (byte_q),
    .line_end   (end_q),
    .state      (state),
    .label      (label),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q       <= 1'b0;
      tok_out.valid <= 1'b0;
      state         <= clt_pkg::SCAN_RESET;
    end else begin
      if (char_in.ready) begin
        valid_q <= char_in.valid;
      end
      if (advance) begin
        tok_out.valid <= 1'b1;
        state         <= state_next;
      end else if (tok_out.ready) begin
        tok_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      byte_q <= char_in.byte_in;
      end_q  <= char_in.line_end;
    end
    if (advance) begin
      tok_out.byte_out     <= byte_q;
      tok_out.role         <= 2'(label.role);
      tok_out.kind         <= 2'(label.kind);
      tok_out.last_of_line <= end_q;
    end
  end

`ifndef SYNTHESIS
  a_drop_is_word: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && tok_out.role == 2'(clt_pkg::ROLE_DROP)
      |-> tok_out.kind == 2'(clt_pkg::KIND_WORD))
    else $error("dropped blank carries a kind other than word");

  a_punct_is_first: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && tok_out.kind == 2'(clt_pkg::KIND_PUNCT)
      |-> tok_out.role == 2'(clt_pkg::ROLE_FIRST))
    else $error("punctuation token is not a first character");

  a_line_end_idle: assert property (@(posedge clk) disable iff (rst)
    advance && end_q |=> state == clt_pkg::SCAN_RESET)
    else $error("scan state not idle after line end");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("scan state changed without a word moving");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> tok_out.valid)
    else $error("result register not loaded after advance");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Config line tokenizer testbench
// Sends short directed lines and then random config lines through the
// character channel with random gaps and output stalls. A scoreboard tracks
// the scan mode and escape flag itself, predicts the label of every accepted
// character and checks each labeled character in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 1100;
  localparam logic [7:0] PUNCT_SET [8] = '{clt_pkg::CHAR_EQUAL, clt_pkg::CHAR_COLON,
    clt_pkg::CHAR_COMMA, clt_pkg::CHAR_MINUS, clt_pkg::CHAR_LBRACKET,
    clt_pkg::CHAR_RBRACKET, clt_pkg::CHAR_LBRACE, clt_pkg::CHAR_RBRACE};

  typedef struct {
    logic [7:0]     ch;
    clt_pkg::role_t role;
    clt_pkg::kind_t kind;
    logic           last;
  } char_label_t;

  class label_scoreboard;
    clt_pkg::mode_t scan_mode;
    bit             after_backslash;
    char_label_t    expected_labels[$];
    int             mismatches;
    int             labels_checked;
    int             kind_count[4];
    int             dropped_count;

    function new();
      scan_mode       = clt_pkg::MODE_IDLE;
      after_backslash = 1'b0;
      mismatches      = 0;
      labels_checked  = 0;
      dropped_count   = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == clt_pkg::CHAR_SPACE || c == clt_pkg::CHAR_TAB;
    endfunction

    function bit punct_char(logic [7:0] c);
      foreach (PUNCT_SET[i]) if (c == PUNCT_SET[i]) return 1'b1;
      return 1'b0;
    endfunction

    function void open_token(logic [7:0] c, output clt_pkg::role_t r,
                             output clt_pkg::kind_t k);
      r = clt_pkg::ROLE_FIRST;
      if (blank_char(c)) begin
        r = clt_pkg::ROLE_DROP;
        k = clt_pkg::KIND_WORD;
        scan_mode = clt_pkg::MODE_IDLE;
      end else if (c == clt_pkg::CHAR_QUOTE) begin
        k = clt_pkg::KIND_STRING;
        scan_mode = clt_pkg::MODE_STRING;
      end else if (punct_char(c)) begin
        k = clt_pkg::KIND_PUNCT;
        scan_mode = clt_pkg::MODE_IDLE;
      end else if (c == clt_pkg::CHAR_HASH) begin
        k = clt_pkg::KIND_COMMENT;
        scan_mode = clt_pkg::MODE_COMMENT;
      end else begin
        k = clt_pkg::KIND_WORD;
        scan_mode = clt_pkg::MODE_WORD;
      end
    endfunction

    function void note_char(logic [7:0] c, logic line_end);
      char_label_t x;
      x.ch   = c;
      x.last = line_end;
      x.role = clt_pkg::ROLE_CONT;
      x.kind = clt_pkg::KIND_WORD;
      case (scan_mode)
        clt_pkg::MODE_WORD: begin
          if (!after_backslash && (blank_char(c) || punct_char(c)))
            open_token(c, x.role, x.kind);
        end
        clt_pkg::MODE_STRING: begin
          x.kind = clt_pkg::KIND_STRING;
          if (c == clt_pkg::CHAR_QUOTE && !after_backslash) scan_mode = clt_pkg::MODE_IDLE;
        end
        clt_pkg::MODE_COMMENT: x.kind = clt_pkg::KIND_COMMENT;
        default: open_token(c, x.role, x.kind);
      endcase
      after_backslash = (c == clt_pkg::CHAR_BACKSLASH);
      if (line_end) begin
        scan_mode = clt_pkg::MODE_IDLE;
        after_backslash = 1'b0;
      end
      expected_labels.push_back(x);
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_label(logic [7:0] ch, logic [1:0] role, logic [1:0] kind, logic last);
      char_label_t x;
      if (expected_labels.size() == 0) begin
        report($sformatf("unexpected word ch=%02h role=%0d kind=%0d last=%0d",
                         ch, role, kind, last));
        return;
      end
      x = expected_labels.pop_front();
      labels_checked++;
      if (x.role == clt_pkg::ROLE_DROP) dropped_count++;
      else kind_count[x.kind]++;
      if (ch !== x.ch) report($sformatf("byte_out %02h, expected %02h", ch, x.ch));
      if (role !== x.role)
        report($sformatf("role %0d, expected %s for ch=%02h", role, x.role.name(), x.ch));
      if (kind !== x.kind)
        report($sformatf("kind %0d, expected %s for ch=%02h", kind, x.kind.name(), x.ch));
      if (last !== x.last)
        report($sformatf("last_of_line %0d, expected %0d for ch=%02h", last, x.last, x.ch));
    endtask

    function int pending();
      return expected_labels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   chars_sent = 0;
  int   lines_sent = 0;
  bit   src_burst = 1'b0;
  bit   snk_burst = 1'b0;
  label_scoreboard sb = new();

  clt_in_if  char_in ();
  clt_out_if tok_out ();

  config_line_tokenizer uut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .tok_out (tok_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("config_line_tokenizer verification failed");
      $finish;
    end
  end

  task send_char(logic [7:0] c, logic line_end);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      char_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_in.valid    <= 1'b1;
    char_in.byte_in  <= c;
    char_in.line_end <= line_end;
    do @(posedge clk); while (!char_in.ready);
    sb.note_char(c, line_end);
    chars_sent++;
    if (line_end) lines_sent++;
  endtask

  task send_line(logic [7:0] line_chars[$]);
    foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 8'h61 + 8'($urandom_range(0, 25));
    else if (sel < 42) return $urandom_range(0, 1) ? clt_pkg::CHAR_SPACE : clt_pkg::CHAR_TAB;
    else if (sel < 57) return PUNCT_SET[3'($urandom_range(0, 7))];
    else if (sel < 67) return clt_pkg::CHAR_QUOTE;
    else if (sel < 72) return clt_pkg::CHAR_HASH;
    else if (sel < 82) return clt_pkg::CHAR_BACKSLASH;
    else return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds a line out of tokens: words with occasional escapes, blank runs,
  // strings with escaped quotes, punctuation and a trailing comment.
  function automatic void build_line(ref logic [7:0] q[$]);
    int n_tok;
    int n;
    n_tok = $urandom_range(1, 7);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 6) == 0) begin
              q.push_back(clt_pkg::CHAR_BACKSLASH);
              q.push_back(pick_char());
            end else if ($urandom_range(0, 9) == 0) begin
              q.push_back($urandom_range(0, 1) ? clt_pkg::CHAR_QUOTE : clt_pkg::CHAR_HASH);
            end else begin
              q.push_back(word_char());
            end
          end
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) q.push_back($urandom_range(0, 1) ? clt_pkg::CHAR_SPACE : clt_pkg::CHAR_TAB);
        end
        3: begin
          q.push_back(clt_pkg::CHAR_QUOTE);
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
              q.push_back(clt_pkg::CHAR_BACKSLASH);
              q.push_back(clt_pkg::CHAR_QUOTE);
            end else begin
              q.push_back(pick_char());
            end
          end
          if ($urandom_range(0, 6) != 0) q.push_back(clt_pkg::CHAR_QUOTE);
        end
        4: q.push_back(PUNCT_SET[3'($urandom_range(0, 7))]);
        default: begin
          if (t == n_tok - 1) begin
            q.push_back(clt_pkg::CHAR_HASH);
            n = $urandom_range(0, 5);
            repeat (n) q.push_back(pick_char());
          end else begin
            q.push_back(pick_char());
          end
        end
      endcase
    end
  endfunction

  task send_directed();
    send_char(8'h00, 1'b0);
    send_char(clt_pkg::CHAR_BACKSLASH, 1'b0);
    send_char(clt_pkg::CHAR_EQUAL, 1'b0);
    send_char(clt_pkg::CHAR_QUOTE, 1'b0);
    send_char(clt_pkg::CHAR_HASH, 1'b0);
    send_char(clt_pkg::CHAR_COLON, 1'b0);
    send_char(clt_pkg::CHAR_COMMA, 1'b0);
    send_char(clt_pkg::CHAR_MINUS, 1'b0);
    send_char(clt_pkg::CHAR_LBRACKET, 1'b0);
    send_char(clt_pkg::CHAR_RBRACKET, 1'b0);
    send_char(clt_pkg::CHAR_LBRACE, 1'b0);
    send_char(clt_pkg::CHAR_RBRACE, 1'b0);
    send_char(clt_pkg::CHAR_TAB, 1'b0);
    send_char(clt_pkg::CHAR_QUOTE, 1'b0);
    send_char(clt_pkg::CHAR_BACKSLASH, 1'b0);
    send_char(clt_pkg::CHAR_QUOTE, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(clt_pkg::CHAR_QUOTE, 1'b0);
    send_char(clt_pkg::CHAR_BACKSLASH, 1'b0);
    send_char(clt_pkg::CHAR_SPACE, 1'b0);
    send_char(clt_pkg::CHAR_SPACE, 1'b0);
    send_char(clt_pkg::CHAR_HASH, 1'b0);
    send_char(clt_pkg::CHAR_QUOTE, 1'b1);
    send_char(clt_pkg::CHAR_BACKSLASH, 1'b1);
    send_char(clt_pkg::CHAR_QUOTE, 1'b0);
    send_char(8'h7f, 1'b1);
  endtask

  initial begin
    logic [7:0] line_chars[$];
    char_in.valid    = 1'b0;
    char_in.byte_in  = 8'h00;
    char_in.line_end = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_directed();
    while (chars_sent < RANDOM_CHARS + 26) begin
      line_chars.delete();
      src_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_line(line_chars);
      end
      send_line(line_chars);
    end
    @(negedge clk);
    char_in.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters on %0d lines; checked %0d labels.",
             chars_sent, lines_sent, sb.labels_checked);
    $display("Labels seen: %0d dropped, %0d word, %0d string, %0d punct, %0d comment.",
             sb.dropped_count, sb.kind_count[clt_pkg::KIND_WORD],
             sb.kind_count[clt_pkg::KIND_STRING], sb.kind_count[clt_pkg::KIND_PUNCT],
             sb.kind_count[clt_pkg::KIND_COMMENT]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("config_line_tokenizer verification clean");
    end else begin
      $display("config_line_tokenizer verification failed");
    end
    $finish;
  end

  initial begin
    int gap;
    tok_out.ready = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 29) == 0) snk_burst = !snk_burst;
      gap = snk_burst ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (gap != 0) begin
        tok_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      tok_out.ready <= 1'b1;
      do @(posedge clk); while (!tok_out.valid);
      sb.check_label(tok_out.byte_out, tok_out.role, tok_out.kind, tok_out.last_of_line);
    end
  end

endmodule
